/* hdl/bht_pkg.sv */
package bht_pkg;

    localparam int OPCODE_W = 3;
    localparam int HOST_W   = 16;
    localparam int SLOT_W   = 7;
    localparam int STATUS_W = 2;
    localparam int USERS_W  = 16;

    localparam logic [USERS_W-1:0] USERS_MAX = {USERS_W{1'b1}};

    typedef enum logic [OPCODE_W-1:0] {
        OP_OPEN     = 3'd0,
        OP_CLOSE    = 3'd1,
        OP_LOOKUP   = 3'd2,
        OP_ADD_USER = 3'd3,
        OP_DROP_USER = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_OPEN = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic read;
        logic commit;
    } bht_cmd_t;

endpackage

/* hdl/bht_ctrl.sv */
module bht_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output bht_pkg::bht_cmd_t cmd
);
    import bht_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ: begin
                cmd.read   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                // result register must be free or draining this cycle
                if (!m_valid_reg || m_ready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

/* hdl/bht_datapath.sv */
module bht_datapath #(
    parameter int SLOTS       = 128,
    parameter int RESERVED    = 3,
    parameter int HANDLE_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bht_pkg::bht_cmd_t              cmd,
    input  logic [bht_pkg::OPCODE_W-1:0]   s_opcode,
    input  logic [bht_pkg::HOST_W-1:0]     s_host_handle,
    input  logic [bht_pkg::SLOT_W-1:0]     s_slot,
    output logic [bht_pkg::STATUS_W-1:0]   m_status,
    output logic [bht_pkg::SLOT_W-1:0]     m_slot_out,
    output logic [bht_pkg::HOST_W-1:0]     m_handle_out,
    output logic [bht_pkg::USERS_W-1:0]    m_user_count
);
    import bht_pkg::*;

    localparam int ROW_BITS   = (SLOTS < 32) ? SLOTS : 32;
    localparam int ROWS       = (SLOTS + ROW_BITS - 1) / ROW_BITS;
    localparam int BIT_IDX_W  = $clog2(ROW_BITS);
    localparam int ROW_IDX_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_IDX_W = $clog2(SLOTS);

    // occupancy bitmap, one row per word; rows not yet written read as reset value
    logic [ROW_BITS-1:0]    bm_mem [ROWS];
    logic [HANDLE_BITS-1:0] hd_mem [SLOTS];

    logic [ROWS-1:0]        row_valid_reg;
    logic [ROWS-1:0]        row_full_reg;
    logic [USERS_W-1:0]     users_reg, users_next;

    logic [OPCODE_W-1:0]    op_reg;
    logic [HOST_W-1:0]      host_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [SLOT_IDX_W-1:0]  slot_idx_reg;
    logic [ROW_IDX_W-1:0]   row_reg;
    logic [BIT_IDX_W-1:0]   bit_reg;
    logic                   in_range_reg;
    logic                   any_free_reg;
    logic [ROW_BITS-1:0]    bm_rd_reg;
    logic [HANDLE_BITS-1:0] hd_rd_reg;

    logic [STATUS_W-1:0]    status_reg;
    logic [SLOT_W-1:0]      slot_out_reg;
    logic [HOST_W-1:0]      handle_out_reg;

    function automatic logic [ROW_BITS-1:0] reset_word(input logic [ROW_IDX_W-1:0] r);
        logic [ROW_BITS-1:0] w;
        int                  idx;
        w = '0;
        for (int b = 0; b < ROW_BITS; b++) begin
            idx  = int'(r) * ROW_BITS + b;
            w[b] = (idx < RESERVED) || (idx >= SLOTS);
        end
        return w;
    endfunction

    // request decode at capture
    logic [SLOT_IDX_W+SLOT_W-1:0] slot_wide;
    logic [SLOT_IDX_W-1:0]        in_slot_idx;
    logic [ROW_IDX_W-1:0]         in_row;
    logic [ROW_IDX_W-1:0]         free_row;
    logic                         free_row_found;

    assign slot_wide   = (SLOT_IDX_W + SLOT_W)'(s_slot);
    assign in_slot_idx = slot_wide[SLOT_IDX_W-1:0];
    assign in_row      = ROW_IDX_W'(slot_wide >> BIT_IDX_W);

    always_comb begin
        free_row_found = 1'b0;
        free_row       = '0;
        for (int r = ROWS - 1; r >= 0; r--) begin
            if (!row_full_reg[r]) begin
                free_row_found = 1'b1;
                free_row       = ROW_IDX_W'(r);
            end
        end
    end

    // execute
    logic [ROW_BITS-1:0]    word;
    logic [ROW_BITS-1:0]    new_word;
    logic [BIT_IDX_W-1:0]   free_bit;
    logic [SLOT_IDX_W-1:0]  claimed_idx;
    logic                   occ;
    logic                   bm_we;
    logic                   hd_we;
    logic [STATUS_W-1:0]    status_next;
    logic [SLOT_W-1:0]      slot_out_next;
    logic [HOST_W-1:0]      handle_out_next;

    always_comb begin
        word = row_valid_reg[row_reg] ? bm_rd_reg : reset_word(row_reg);
        free_bit = '0;
        for (int b = ROW_BITS - 1; b >= 0; b--) begin
            if (!word[b]) begin
                free_bit = BIT_IDX_W'(b);
            end
        end
        claimed_idx = SLOT_IDX_W'(32'(row_reg) * ROW_BITS + 32'(free_bit));
        occ         = in_range_reg && word[bit_reg];

        new_word        = word;
        bm_we           = 1'b0;
        hd_we           = 1'b0;
        status_next     = ST_OK;
        slot_out_next   = slot_reg;
        handle_out_next = '0;
        users_next      = users_reg;

        case (op_reg)
            OP_OPEN: begin
                if (any_free_reg) begin
                    new_word[free_bit] = 1'b1;
                    bm_we              = 1'b1;
                    hd_we              = 1'b1;
                    slot_out_next      = SLOT_W'({{SLOT_W{1'b0}}, claimed_idx});
                end else begin
                    status_next = ST_FULL;
                end
            end
            OP_CLOSE: begin
                if (occ) begin
                    new_word[bit_reg] = 1'b0;
                    bm_we             = 1'b1;
                end else begin
                    status_next = ST_NOT_OPEN;
                end
            end
            OP_LOOKUP: begin
                if (occ) begin
                    handle_out_next = HOST_W'(hd_rd_reg);
                end else begin
                    status_next = ST_NOT_OPEN;
                end
            end
            OP_ADD_USER: begin
                if (users_reg != USERS_MAX) begin
                    users_next = users_reg + 1'b1;
                end
            end
            OP_DROP_USER: begin
                if (users_reg != '0) begin
                    users_next = users_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            users_reg     <= '0;
            row_valid_reg <= '0;
            for (int r = 0; r < ROWS; r++) begin
                row_full_reg[r] <= &reset_word(ROW_IDX_W'(r));
            end
        end else if (cmd.commit) begin
            users_reg <= users_next;
            if (bm_we) begin
                row_valid_reg[row_reg] <= 1'b1;
                row_full_reg[row_reg]  <= &new_word;
            end
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg       <= s_opcode;
            host_reg     <= s_host_handle;
            slot_reg     <= s_slot;
            slot_idx_reg <= in_slot_idx;
            bit_reg      <= slot_wide[BIT_IDX_W-1:0];
            in_range_reg <= 32'(s_slot) < SLOTS;
            any_free_reg <= free_row_found;
            row_reg      <= (s_opcode == OP_OPEN) ? free_row : in_row;
        end
        if (cmd.commit) begin
            status_reg     <= status_next;
            slot_out_reg   <= slot_out_next;
            handle_out_reg <= handle_out_next;
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            bm_rd_reg <= bm_mem[row_reg];
            hd_rd_reg <= hd_mem[slot_idx_reg];
        end
        if (cmd.commit && bm_we) begin
            bm_mem[row_reg] <= new_word;
        end
        if (cmd.commit && hd_we) begin
            hd_mem[claimed_idx] <= HANDLE_BITS'(host_reg);
        end
    end

    assign m_status     = status_reg;
    assign m_slot_out   = slot_out_reg;
    assign m_handle_out = handle_out_reg;
    assign m_user_count = users_reg;

endmodule

/* hdl/bitmap_handle_table_core.sv */
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_opcode, s_host_handle, s_slot
// m_        out        m_valid / m_ready  m_status, m_slot_out, m_handle_out, m_user_count
//
// Each request steps through capture, memory read and execute in turn. Open picks the
// lowest non-full bitmap row from per-row full flags, then the lowest free bit.
// Execute waits while a previous result is still held in the output register.
// Reset is synchronous, active low; the bitmap needs no clearing pass (per-row
// valid flags), so the core accepts requests right after reset.
module bitmap_handle_table_core #(
    parameter int SLOTS       = 128,
    parameter int RESERVED    = 3,
    parameter int HANDLE_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bht_pkg::OPCODE_W-1:0]   s_opcode,
    input  logic [bht_pkg::HOST_W-1:0]     s_host_handle,
    input  logic [bht_pkg::SLOT_W-1:0]     s_slot,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bht_pkg::STATUS_W-1:0]   m_status,
    output logic [bht_pkg::SLOT_W-1:0]     m_slot_out,
    output logic [bht_pkg::HOST_W-1:0]     m_handle_out,
    output logic [bht_pkg::USERS_W-1:0]    m_user_count
);
    import bht_pkg::*;

    bht_cmd_t cmd;

    bht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    bht_datapath #(
        .SLOTS       (SLOTS),
        .RESERVED    (RESERVED),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_opcode      (s_opcode),
        .s_host_handle (s_host_handle),
        .s_slot        (s_slot),
        .m_status      (m_status),
        .m_slot_out    (m_slot_out),
        .m_handle_out  (m_handle_out),
        .m_user_count  (m_user_count)
    );

endmodule

/* bench/bht_checker.sv */
module bht_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [bht_pkg::OPCODE_W-1:0]   s_opcode,
    input  logic [bht_pkg::HOST_W-1:0]     s_host_handle,
    input  logic [bht_pkg::SLOT_W-1:0]     s_slot,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [bht_pkg::STATUS_W-1:0]   m_status,
    input  logic [bht_pkg::SLOT_W-1:0]     m_slot_out,
    input  logic [bht_pkg::HOST_W-1:0]     m_handle_out,
    input  logic [bht_pkg::USERS_W-1:0]    m_user_count,
    output int                             errors,
    output int                             pending
);
    import bht_pkg::*;

    localparam int N_SLOTS    = 128;
    localparam int N_RESERVED = 3;

    typedef struct packed {
        status_t               status;
        logic [SLOT_W-1:0]     slot;
        logic [HOST_W-1:0]     handle;
        logic [USERS_W-1:0]    users;
    } reply_t;

    logic [N_SLOTS-1:0]   slot_busy;
    logic [HOST_W-1:0]    handles [N_SLOTS];
    logic [USERS_W-1:0]   user_cnt;
    reply_t               replies_due [$];
    int                   n_req;
    int                   n_rsp;

    assign pending = n_req - n_rsp;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (errors < 40) begin
            $display("%0t bht: %s got 0x%0h want 0x%0h", $time, what, got, want);
        end
        errors++;
    endtask

    function automatic reply_t table_step(input logic [OPCODE_W-1:0] op,
                                          input logic [HOST_W-1:0]   host,
                                          input logic [SLOT_W-1:0]   slot);
        reply_t r;
        r.status = ST_OK;
        r.slot   = slot;
        r.handle = '0;
        case (op)
            OP_OPEN: begin
                r.status = ST_FULL;
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (!slot_busy[i]) begin
                        slot_busy[i] = 1'b1;
                        handles[i]   = host;
                        r.slot       = SLOT_W'(i);
                        r.status     = ST_OK;
                        break;
                    end
                end
            end
            OP_CLOSE: begin
                if (slot_busy[slot]) begin
                    slot_busy[slot] = 1'b0;
                end else begin
                    r.status = ST_NOT_OPEN;
                end
            end
            OP_LOOKUP: begin
                if (slot_busy[slot]) begin
                    r.handle = handles[slot];
                end else begin
                    r.status = ST_NOT_OPEN;
                end
            end
            OP_ADD_USER: begin
                if (user_cnt != USERS_MAX) begin
                    user_cnt = user_cnt + 1'b1;
                end
            end
            OP_DROP_USER: begin
                if (user_cnt != '0) begin
                    user_cnt = user_cnt - 1'b1;
                end
            end
            default: ;
        endcase
        r.users = user_cnt;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        reply_t want;
        if (!aresetn) begin
            errors = 0;
            slot_busy = '0;
            slot_busy[N_RESERVED-1:0] = '1;
            for (int i = 0; i < N_SLOTS; i++) begin
                handles[i] = '0;
            end
            user_cnt = '0;
            replies_due.delete();
            n_req <= 0;
            n_rsp <= 0;
        end else begin
            if (s_valid && s_ready) begin
                replies_due.push_back(table_step(s_opcode, s_host_handle, s_slot));
                n_req <= n_req + 1;
            end
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    report("reply with no request outstanding", 32'(m_slot_out), '0);
                end else begin
                    want = replies_due.pop_front();
                    n_rsp <= n_rsp + 1;
                    if (m_status !== want.status)
                        report("status", 32'(m_status), 32'(want.status));
                    if (m_slot_out !== want.slot)
                        report("slot_out", 32'(m_slot_out), 32'(want.slot));
                    if (m_handle_out !== want.handle)
                        report("handle_out", 32'(m_handle_out), 32'(want.handle));
                    if (m_user_count !== want.users)
                        report("user_count", 32'(m_user_count), 32'(want.users));
                end
            end
        end
    end

endmodule

/* bench/tb_top.sv */
module tb_top;
    import bht_pkg::*;

    localparam int N_SLOTS     = 128;
    localparam int N_RESERVED  = 3;
    localparam int RAND_ITEMS  = 700;
    localparam int CLIMB_ITEMS = 40;
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = OPCODE_W'(OP_DROP_USER + 1);
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = '1;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [OPCODE_W-1:0]    s_opcode;
    logic [HOST_W-1:0]      s_host_handle;
    logic [SLOT_W-1:0]      s_slot;
    logic                   m_valid;
    logic                   m_ready;
    logic [STATUS_W-1:0]    m_status;
    logic [SLOT_W-1:0]      m_slot_out;
    logic [HOST_W-1:0]      m_handle_out;
    logic [USERS_W-1:0]     m_user_count;
    int                     errors;
    int                     pending;

    // shadow of occupancy, used to aim close and lookup requests and to tell when the table is full
    logic [N_SLOTS-1:0]     occ;
    logic [N_RESERVED-1:0]  fresh;
    bit                     src_quiet;
    bit                     sink_quiet;
    int                     n_items;

    bitmap_handle_table_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_host_handle (s_host_handle),
        .s_slot        (s_slot),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot_out    (m_slot_out),
        .m_handle_out  (m_handle_out),
        .m_user_count  (m_user_count)
    );

    bht_checker u_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_host_handle (s_host_handle),
        .s_slot        (s_slot),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot_out    (m_slot_out),
        .m_handle_out  (m_handle_out),
        .m_user_count  (m_user_count),
        .errors        (errors),
        .pending       (pending)
    );

    initial begin : clk_gen
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin : watchdog
        #24000000;
        $display("bitmap_handle_table_core: mismatch");
        $finish;
    end

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [HOST_W-1:0] rand_host();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return HOST_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [SLOT_W-1:0] rand_slot();
        return SLOT_W'($urandom_range(0, N_SLOTS - 1));
    endfunction

    function automatic logic [SLOT_W-1:0] pick_used();
        logic [SLOT_W-1:0] k;
        k = rand_slot();
        for (int i = 0; i < N_SLOTS; i++) begin
            if (occ[k]) return k;
            k = k + 1'b1;
        end
        return rand_slot();
    endfunction

    task automatic issue(input logic [OPCODE_W-1:0] op,
                         input logic [HOST_W-1:0]   host,
                         input logic [SLOT_W-1:0]   slot);
        logic [SLOT_W-1:0] s;
        int gap;
        s = slot;
        case (op)
            OP_OPEN: begin
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (!occ[i]) begin
                        occ[i] = 1'b1;
                        break;
                    end
                end
            end
            OP_CLOSE: begin
                occ[s] = 1'b0;
                if (s < N_RESERVED) fresh[s[1:0]] = 1'b0;
            end
            OP_LOOKUP: begin
                // reserved slots hold no handle until reopened
                if (s < N_RESERVED && fresh[s[1:0]]) s = s + SLOT_W'(N_RESERVED);
            end
            default: ;
        endcase
        if (op <= OP_DROP_USER) n_items++;
        gap = pick_gap(src_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_host_handle <= host;
        s_slot        <= s;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            issue(OP_OPEN, rand_host(), rand_slot());
        else if (r < 45)
            issue(OP_CLOSE, rand_host(), ($urandom_range(0, 4) != 0) ? pick_used() : rand_slot());
        else if (r < 70)
            issue(OP_LOOKUP, rand_host(), ($urandom_range(0, 4) != 0) ? pick_used() : rand_slot());
        else if (r < 80)
            issue(OP_ADD_USER, rand_host(), rand_slot());
        else if (r < 92)
            issue(OP_DROP_USER, rand_host(), rand_slot());
        else
            issue(OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), rand_host(), rand_slot());
    endtask

    initial begin : sink
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (sink_quiet) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                stall = pick_gap(1'b0);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    initial begin : stim
        int kind;
        int len;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_opcode      <= OP_OPEN;
        s_host_handle <= '0;
        s_slot        <= '0;
        occ = '0;
        occ[N_RESERVED-1:0] = '1;
        fresh = '1;
        src_quiet = 1'b0;
        sink_quiet = 1'b0;
        n_items = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        issue(OP_LOOKUP, 16'h1234, 7'd5);
        issue(OP_CLOSE, 16'h0000, 7'd127);
        issue(OP_DROP_USER, 16'hFFFF, 7'd0);
        issue(OP_OPEN, 16'hFFFF, 7'd0);
        issue(OP_OPEN, 16'h0000, 7'd127);
        issue(OP_OPEN, 16'hFFFF, 7'd64);
        issue(OP_LOOKUP, 16'h0000, 7'd3);
        issue(OP_LOOKUP, 16'hFFFF, 7'd4);
        issue(OP_LOOKUP, 16'h0000, 7'd5);
        issue(OP_ADD_USER, 16'h0000, 7'd0);
        issue(OP_ADD_USER, 16'hFFFF, 7'd127);
        issue(OP_DROP_USER, 16'h0000, 7'd0);
        issue(OP_SPARE_LO, 16'hFFFF, 7'd127);
        issue(OP_SPARE_LO + 1'b1, 16'h5555, 7'd42);
        issue(OP_SPARE_HI, 16'h0000, 7'd0);
        issue(OP_CLOSE, 16'h0000, 7'd1);
        issue(OP_LOOKUP, 16'h0000, 7'd1);
        issue(OP_OPEN, 16'hA5A5, 7'd0);
        issue(OP_LOOKUP, 16'h0000, 7'd1);
        issue(OP_CLOSE, 16'h0000, 7'd4);
        issue(OP_CLOSE, 16'h0000, 7'd4);
        issue(OP_OPEN, 16'h5A5A, 7'd0);
        issue(OP_LOOKUP, 16'h0000, 7'd127);

        // fill the table, then open into a full table
        while (!(&occ)) issue(OP_OPEN, rand_host(), rand_slot());
        repeat (3) issue(OP_OPEN, rand_host(), rand_slot());
        wait_drained();

        n_items = 0;
        while (n_items < RAND_ITEMS) begin
            src_quiet  = ($urandom_range(0, 5) == 0);
            sink_quiet = ($urandom_range(0, 5) == 0);
            kind = $urandom_range(0, 9);
            len  = $urandom_range(4, 40);
            if (kind == 0) begin
                while (!(&occ)) issue(OP_OPEN, rand_host(), rand_slot());
                repeat ($urandom_range(1, 3)) issue(OP_OPEN, rand_host(), rand_slot());
            end else if (kind == 1) begin
                repeat (len) issue(OP_OPEN, rand_host(), rand_slot());
            end else if (kind < 4) begin
                repeat (len) issue(OP_CLOSE, rand_host(), pick_used());
            end else if (kind == 4) begin
                wait_drained();
            end else begin
                repeat (len) random_op();
            end
        end
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
        wait_drained();

        // back-to-back add-user burst
        src_quiet  = 1'b1;
        sink_quiet = 1'b1;
        repeat (CLIMB_ITEMS) issue(OP_ADD_USER, rand_host(), rand_slot());
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
        repeat (12) random_op();

        wait_drained();
        repeat (16) @(posedge aclk);
        if (errors == 0) begin
            $display("bitmap_handle_table_core: match");
        end else begin
            $display("bitmap_handle_table_core: mismatch");
        end
        $finish;
    end

endmodule

/* bitmap_handle_table_core.f */
hdl/bht_pkg.sv
hdl/bht_ctrl.sv
hdl/bht_datapath.sv
hdl/bitmap_handle_table_core.sv
bench/bht_checker.sv
bench/tb_top.sv
